@@ rtl/pose_target_velocity_controller_macros.svh @@
// Assertion macros shared by the pose controller RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef POSE_TARGET_VELOCITY_CONTROLLER_MACROS_SVH
`define POSE_TARGET_VELOCITY_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTVC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTVC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ptvc_pkg.sv @@
// Shared constants, codes and arithmetic helpers of the pose controller.
// Depends on nothing; imported by every module of the block but the RAM.
`default_nettype none

package ptvc_pkg;

    // Field widths.
    localparam int unsigned POS_W   = 32;
    localparam int unsigned Q_W     = 16;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned PDB_W   = 31;
    localparam int unsigned RDB_W   = 19;
    localparam int unsigned LINK_W  = 4;
    localparam int unsigned CFG_AW  = 2;
    localparam int unsigned CFG_DW  = 32;
    localparam int unsigned TGT_W   = 3 * POS_W + 4 * Q_W;

    // Iterative unit sizes.
    localparam int unsigned SQRT_IN_W  = 64;
    localparam int unsigned SQRT_OUT_W = 32;
    localparam int unsigned DIV_NUM_W  = 47;
    localparam int unsigned DIV_DEN_W  = 31;
    localparam int unsigned DIV_Q_W    = 17;
    localparam int unsigned CORDIC_N   = 24;

    // Item function codes.
    localparam logic FUNC_STORE  = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_LIN_GAIN = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_ANG_GAIN = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_POS_DB   = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_ROT_DB   = 2'd3;

    // Register reset values: gains 10.0 in Q8.8, deadbands 0.1 in Q.16.
    localparam logic [GAIN_W-1:0] LIN_GAIN_RST = 16'd2560;
    localparam logic [GAIN_W-1:0] ANG_GAIN_RST = 16'd2560;
    localparam logic [PDB_W-1:0]  POS_DB_RST   = 31'd6554;
    localparam logic [RDB_W-1:0]  ROT_DB_RST   = 19'd6554;

    // Fixed-point constants.
    localparam logic signed [Q_W-1:0] Q_ONE   = 16'sd16384;
    localparam logic signed [31:0]    W_ONE   = 32'sd268435456;
    localparam logic signed [31:0]    PI_Q24  = 32'sd52707179;

    // Arctangent table in Q.24 for the CORDIC steps.
    function automatic logic signed [31:0] atan_q24(input logic [4:0] idx);
        logic signed [31:0] r;
        case (idx)
            5'd0:    r = 32'sd13176795;
            5'd1:    r = 32'sd7778716;
            5'd2:    r = 32'sd4110060;
            5'd3:    r = 32'sd2086331;
            5'd4:    r = 32'sd1047214;
            5'd5:    r = 32'sd524117;
            5'd6:    r = 32'sd262123;
            5'd7:    r = 32'sd131069;
            5'd8:    r = 32'sd65536;
            5'd9:    r = 32'sd32768;
            5'd10:   r = 32'sd16384;
            5'd11:   r = 32'sd8192;
            5'd12:   r = 32'sd4096;
            5'd13:   r = 32'sd2048;
            5'd14:   r = 32'sd1024;
            5'd15:   r = 32'sd512;
            5'd16:   r = 32'sd256;
            5'd17:   r = 32'sd128;
            5'd18:   r = 32'sd64;
            5'd19:   r = 32'sd32;
            5'd20:   r = 32'sd16;
            5'd21:   r = 32'sd8;
            5'd22:   r = 32'sd4;
            5'd23:   r = 32'sd2;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    // Clamp a quaternion component to the unit range.
    function automatic logic signed [Q_W-1:0] clamp_q(input logic signed [Q_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > Q_ONE) begin
            r = Q_ONE;
        end else if (v < -Q_ONE) begin
            r = -Q_ONE;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/pose_target_velocity_controller.sv @@
// Top level of the per-link pose target store and deadband pose controller.
// Depends on ptvc_pkg, ptvc_ram, ptvc_sqrt, ptvc_div and the macros header.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_ready | func, link_index, pos_*, quat_*
//  out     | output    | o_out_valid/i_out_ready | out_link, lin_v*, ang_v*
//  cfg     | input     | i_cfg_valid/o_cfg_ready | cfg_index, cfg_data
//
// An update whose rotation error has no vector part skips the angle steps; one
// whose angle is inside the deadband runs a 32-step square root pass and the
// 24-step CORDIC loop; any other also runs a second 32-step square root pass
// and three 17-step divisions. Reset is synchronous, active low, and clears the
// link valid bits and the configuration registers; the target RAM is not
// cleared. A finished result waits in the output register while the next input
// transaction is taken; a further result stalls only until that one is taken.
`default_nettype none

`include "pose_target_velocity_controller_macros.svh"

module pose_target_velocity_controller
    import ptvc_pkg::*;
#(
    parameter int unsigned LINKS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Input items.
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_func,
    input  wire logic [LINK_W-1:0]        i_link_index,
    input  wire logic signed [POS_W-1:0]  i_pos_x,
    input  wire logic signed [POS_W-1:0]  i_pos_y,
    input  wire logic signed [POS_W-1:0]  i_pos_z,
    input  wire logic signed [Q_W-1:0]    i_quat_w,
    input  wire logic signed [Q_W-1:0]    i_quat_x,
    input  wire logic signed [Q_W-1:0]    i_quat_y,
    input  wire logic signed [Q_W-1:0]    i_quat_z,
    // Result items.
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [LINK_W-1:0]             o_out_link,
    output logic signed [POS_W-1:0]       o_lin_vx,
    output logic signed [POS_W-1:0]       o_lin_vy,
    output logic signed [POS_W-1:0]       o_lin_vz,
    output logic signed [POS_W-1:0]       o_ang_vx,
    output logic signed [POS_W-1:0]       o_ang_vy,
    output logic signed [POS_W-1:0]       o_ang_vz,
    // Configuration writes.
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_AW-1:0]        i_cfg_index,
    input  wire logic [CFG_DW-1:0]        i_cfg_data
);

    localparam int unsigned AW = (LINKS > 1) ? $clog2(LINKS) : 1;

    typedef enum logic [13:0] {
        S_IDLE   = 14'h0001,
        S_READ   = 14'h0002,
        S_SQ     = 14'h0004,
        S_LIN    = 14'h0008,
        S_QV     = 14'h0010,
        S_ACOS   = 14'h0020,
        S_SQRTW  = 14'h0040,
        S_CORDIC = 14'h0080,
        S_ANG    = 14'h0100,
        S_DIVGO  = 14'h0200,
        S_DIVW   = 14'h0400,
        S_AMUL   = 14'h0800,
        S_AOUT   = 14'h1000,
        S_FIN    = 14'h2000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [GAIN_W-1:0] r_lin_gain, r_ang_gain;
    logic [PDB_W-1:0]  r_pos_db;
    logic [RDB_W-1:0]  r_rot_db;

    // Link bookkeeping.
    logic [LINKS-1:0]  r_valid;
    logic [LINK_W-1:0] r_link;
    logic              w_in_acc, w_link_ok, w_go, w_we;
    logic [AW-1:0]     w_addr;
    logic [TGT_W-1:0]  w_rd;

    // Working registers.
    logic signed [POS_W-1:0] r_cur_p [3];
    logic signed [Q_W-1:0]   r_cur_q [4];
    logic signed [Q_W-1:0]   r_t [4];
    logic signed [Q_W-1:0]   r_c [4];
    logic signed [POS_W:0]   r_e [3];
    logic signed [31:0]      r_v [4];
    logic [4:0]              r_cnt;
    logic                    r_pass, r_sqsel, r_move;
    logic [1:0]              r_k;
    logic [61:0]             r_prod, r_last;
    logic [63:0]             r_acc;
    logic signed [49:0]      r_lprod;
    logic [31:0]             r_lin [3];
    logic [31:0]             r_ang [3];
    logic signed [31:0]      r_x, r_y, r_z;
    logic [RDB_W-1:0]        r_angle;
    logic [DIV_DEN_W-1:0]    r_norm;
    logic [34:0]             r_ga;
    logic [DIV_Q_W-1:0]      r_ax;
    logic [51:0]             r_aprod;
    logic                    r_out_valid;
    logic [LINK_W-1:0]       r_out_link;
    logic [31:0]             r_out_lin [3];
    logic [31:0]             r_out_ang [3];

    // Combinational helpers.
    logic [POS_W:0]          w_emag [3];
    logic                    w_big;
    logic signed [31:0]      w_wcl;
    logic [28:0]             w_wmag;
    logic [30:0]             w_sq_op;
    logic signed [Q_W-1:0]   w_qa [4];
    logic signed [Q_W-1:0]   w_qb [4];
    logic [3:0]              w_qneg;
    logic signed [31:0]      w_vsum;
    logic signed [31:0]      w_th_raw, w_th;
    logic [RDB_W-1:0]        w_angle;
    logic [30:0]             w_vmag_k;
    logic                    w_vneg_k;
    logic signed [53:0]      w_sprod;
    logic                    w_out_free;
    logic                    w_sq_start, w_sq_done;
    logic [SQRT_IN_W-1:0]    w_sq_rad;
    logic [SQRT_OUT_W-1:0]   w_sq_root;
    logic                    w_dv_start, w_dv_done;
    logic [DIV_NUM_W-1:0]    w_dv_num;
    logic [DIV_Q_W-1:0]      w_dv_quot;

    // Input acceptance and link decode.
    assign o_in_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_addr     = AW'(i_link_index);
    assign w_link_ok  = (32'(i_link_index) < 32'(LINKS));
    assign w_we       = w_in_acc && (i_func == FUNC_STORE) && w_link_ok;
    assign w_go       = w_in_acc && (i_func == FUNC_UPDATE) && w_link_ok && r_valid[w_addr];
    assign w_out_free = !r_out_valid || i_out_ready;

    // Target store: x, y, z positions then w, x, y, z quaternion components.
    ptvc_ram #(
        .WIDTH (TGT_W),
        .DEPTH (LINKS)
    ) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata ({i_quat_z, i_quat_y, i_quat_x, i_quat_w, i_pos_z, i_pos_y, i_pos_x}),
        .i_re    (w_in_acc),
        .i_raddr (w_addr),
        .o_rdata (w_rd)
    );

    ptvc_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand (w_sq_rad),
        .o_done     (w_sq_done),
        .o_root     (w_sq_root)
    );

    ptvc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_num   (w_dv_num),
        .i_den   (r_norm),
        .o_done  (w_dv_done),
        .o_quot  (w_dv_quot)
    );

    // Error magnitudes and the per-axis deadband test.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_emag[k] = r_e[k][POS_W] ? (POS_W+1)'(-r_e[k]) : (POS_W+1)'(r_e[k]);
        end
        w_big = (w_emag[0] > {2'b00, r_pos_db}) || (w_emag[1] > {2'b00, r_pos_db}) ||
                (w_emag[2] > {2'b00, r_pos_db});
    end

    // Scalar part of the error quaternion clamped to one.
    always_comb begin
        if (r_v[0] > W_ONE) begin
            w_wcl = W_ONE;
        end else if (r_v[0] < -W_ONE) begin
            w_wcl = -W_ONE;
        end else begin
            w_wcl = r_v[0];
        end
        w_wmag = w_wcl[31] ? 29'(-w_wcl) : 29'(w_wcl);
    end

    // Operand of the shared squaring multiplier.
    always_comb begin
        w_sq_op = '0;
        if (r_pass) begin
            if (r_cnt[1:0] == 2'd3) begin
                w_sq_op = 31'(w_wmag);
            end else begin
                w_sq_op = r_v[2'(r_cnt[1:0] + 2'd1)][31] ?
                          31'(-r_v[2'(r_cnt[1:0] + 2'd1)]) :
                          31'(r_v[2'(r_cnt[1:0] + 2'd1)]);
            end
        end else begin
            if (r_cnt[1:0] == 2'd3) begin
                w_sq_op = r_pos_db;
            end else begin
                w_sq_op = w_emag[r_cnt[1:0]][30:0];
            end
        end
    end

    // Operand selection for one component of target times conjugate of current.
    always_comb begin
        w_qneg = 4'b0000;
        w_qa[0] = r_t[0]; w_qb[0] = r_c[0];
        w_qa[1] = r_t[1]; w_qb[1] = r_c[1];
        w_qa[2] = r_t[2]; w_qb[2] = r_c[2];
        w_qa[3] = r_t[3]; w_qb[3] = r_c[3];
        case (r_cnt[1:0])
            2'd1: begin
                w_qa[0] = r_c[0]; w_qb[0] = r_t[1];
                w_qa[1] = r_t[0]; w_qb[1] = r_c[1];
                w_qa[2] = r_t[2]; w_qb[2] = r_c[3];
                w_qa[3] = r_t[3]; w_qb[3] = r_c[2];
                w_qneg  = 4'b0110;
            end
            2'd2: begin
                w_qa[0] = r_c[0]; w_qb[0] = r_t[2];
                w_qa[1] = r_t[0]; w_qb[1] = r_c[2];
                w_qa[2] = r_t[3]; w_qb[2] = r_c[1];
                w_qa[3] = r_t[1]; w_qb[3] = r_c[3];
                w_qneg  = 4'b0110;
            end
            2'd3: begin
                w_qa[0] = r_c[0]; w_qb[0] = r_t[3];
                w_qa[1] = r_t[0]; w_qb[1] = r_c[3];
                w_qa[2] = r_t[1]; w_qb[2] = r_c[2];
                w_qa[3] = r_t[2]; w_qb[3] = r_c[1];
                w_qneg  = 4'b0110;
            end
            default: begin
                w_qneg = 4'b0000;
            end
        endcase
        w_vsum = '0;
        for (int i = 0; i < 4; i++) begin
            if (w_qneg[i]) begin
                w_vsum = w_vsum - 32'(w_qa[i] * w_qb[i]);
            end else begin
                w_vsum = w_vsum + 32'(w_qa[i] * w_qb[i]);
            end
        end
    end

    // Doubled angle from the CORDIC phase, folded for a negative scalar part.
    always_comb begin
        w_th_raw = r_v[0][31] ? (PI_Q24 - r_z) : r_z;
        if (w_th_raw < 0) begin
            w_th = '0;
        end else if (w_th_raw > PI_Q24) begin
            w_th = PI_Q24;
        end else begin
            w_th = w_th_raw;
        end
        w_angle = RDB_W'((w_th + 32'sd64) >>> 7);
    end

    // Axis component selection and signed gain-angle-axis product.
    always_comb begin
        w_vneg_k = r_v[2'(r_k + 2'd1)][31];
        w_vmag_k = w_vneg_k ? 31'(-r_v[2'(r_k + 2'd1)]) : 31'(r_v[2'(r_k + 2'd1)]);
        w_sprod  = w_vneg_k ? -$signed({2'b00, r_aprod}) : $signed({2'b00, r_aprod});
    end

    // Start strobes and operands of the iterative units.
    assign w_sq_start = ((r_state == S_ACOS) && (r_acc != '0)) ||
                        ((r_state == S_ANG) && (w_angle > r_rot_db));
    assign w_sq_rad   = (r_state == S_ANG) ? r_acc : ((64'd1 << 56) - {2'b00, r_last});
    assign w_dv_start = (r_state == S_DIVGO);
    assign w_dv_num   = {w_vmag_k, 16'h0000} + DIV_NUM_W'(r_norm >> 1);

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_go) n_state = S_READ;
            S_READ:   n_state = S_SQ;
            S_SQ:     if (r_cnt == 5'd4) n_state = r_pass ? S_ACOS : S_LIN;
            S_LIN:    if (r_cnt == 5'd3) n_state = S_QV;
            S_QV:     if (r_cnt == 5'd3) n_state = S_SQ;
            S_ACOS:   n_state = (r_acc == '0) ? S_FIN : S_SQRTW;
            S_SQRTW:  if (w_sq_done) n_state = r_sqsel ? S_DIVGO : S_CORDIC;
            S_CORDIC: if (r_cnt == 5'(CORDIC_N - 1)) n_state = S_ANG;
            S_ANG:    n_state = (w_angle > r_rot_db) ? S_SQRTW : S_FIN;
            S_DIVGO:  n_state = S_DIVW;
            S_DIVW:   if (w_dv_done) n_state = S_AMUL;
            S_AMUL:   n_state = S_AOUT;
            S_AOUT:   n_state = (r_k == 2'd2) ? S_FIN : S_DIVGO;
            S_FIN:    if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_lin_gain  <= LIN_GAIN_RST;
            r_ang_gain  <= ANG_GAIN_RST;
            r_pos_db    <= POS_DB_RST;
            r_rot_db    <= ROT_DB_RST;
        end else begin
            r_state <= n_state;
            if (w_we) begin
                r_valid[w_addr] <= 1'b1;
            end
            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LIN_GAIN: r_lin_gain <= i_cfg_data[GAIN_W-1:0];
                    CFG_ANG_GAIN: r_ang_gain <= i_cfg_data[GAIN_W-1:0];
                    CFG_POS_DB:   r_pos_db   <= i_cfg_data[PDB_W-1:0];
                    CFG_ROT_DB:   r_rot_db   <= i_cfg_data[RDB_W-1:0];
                    default:      r_pos_db   <= r_pos_db;
                endcase
            end
        end
    end

    // Datapath registers, stepped by the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                // Latch the current pose of the transaction.
                r_link     <= i_link_index;
                r_cur_p[0] <= i_pos_x;
                r_cur_p[1] <= i_pos_y;
                r_cur_p[2] <= i_pos_z;
                r_cur_q[0] <= clamp_q(i_quat_w);
                r_cur_q[1] <= clamp_q(i_quat_x);
                r_cur_q[2] <= clamp_q(i_quat_y);
                r_cur_q[3] <= clamp_q(i_quat_z);
                r_cnt      <= '0;
            end
            S_READ: begin
                // Position errors and clamped quaternions.
                for (int k = 0; k < 3; k++) begin
                    r_e[k] <= (POS_W+1)'($signed(w_rd[k*POS_W +: POS_W])) -
                              (POS_W+1)'(r_cur_p[k]);
                    r_ang[k] <= '0;
                end
                for (int k = 0; k < 4; k++) begin
                    r_t[k] <= clamp_q($signed(w_rd[3*POS_W + k*Q_W +: Q_W]));
                    r_c[k] <= r_cur_q[k];
                end
                r_pass <= 1'b0;
                r_acc  <= '0;
                r_cnt  <= '0;
            end
            S_SQ: begin
                // Three squares summed, the fourth kept for comparison.
                if (r_cnt != 5'd4) begin
                    r_prod <= 62'(w_sq_op * w_sq_op);
                end
                if (r_cnt == 5'd4) begin
                    r_last <= r_prod;
                end else if (r_cnt != 5'd0) begin
                    r_acc <= r_acc + 64'(r_prod);
                end
                r_cnt <= (r_cnt == 5'd4) ? 5'd0 : (r_cnt + 5'd1);
            end
            S_LIN: begin
                // Gain times error, rounded to Q.16 and saturated; zero inside the deadband.
                if (r_cnt == 5'd0) begin
                    r_move <= w_big || (r_acc > 64'(r_last));
                end
                if (r_cnt != 5'd3) begin
                    r_lprod <= $signed({1'b0, r_lin_gain}) * r_e[r_cnt[1:0]];
                end
                if (r_cnt != 5'd0) begin
                    r_lin[2'(r_cnt[1:0] - 2'd1)] <= r_move ?
                        sat32((64'(r_lprod) + 64'sd128) >>> 8) : 32'h0000_0000;
                end
                r_cnt <= (r_cnt == 5'd3) ? 5'd0 : (r_cnt + 5'd1);
            end
            S_QV: begin
                // One error quaternion component per cycle.
                r_v[r_cnt[1:0]] <= w_vsum;
                if (r_cnt == 5'd3) begin
                    r_pass <= 1'b1;
                    r_acc  <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_cnt <= r_cnt + 5'd1;
                end
            end
            S_ACOS: begin
                r_sqsel <= 1'b0;
            end
            S_SQRTW: begin
                r_ga <= r_ang_gain * r_angle;
                if (w_sq_done) begin
                    if (r_sqsel) begin
                        r_norm <= w_sq_root[DIV_DEN_W-1:0];
                        r_k    <= '0;
                    end else begin
                        r_x   <= $signed(32'(w_wmag));
                        r_y   <= $signed(w_sq_root);
                        r_z   <= '0;
                        r_cnt <= '0;
                    end
                end
            end
            S_CORDIC: begin
                // Vectoring step toward the x axis.
                if (!r_y[31]) begin
                    r_x <= r_x + (r_y >>> r_cnt);
                    r_y <= r_y - (r_x >>> r_cnt);
                    r_z <= r_z + atan_q24(r_cnt);
                end else begin
                    r_x <= r_x - (r_y >>> r_cnt);
                    r_y <= r_y + (r_x >>> r_cnt);
                    r_z <= r_z - atan_q24(r_cnt);
                end
                r_cnt <= (r_cnt == 5'(CORDIC_N - 1)) ? 5'd0 : (r_cnt + 5'd1);
            end
            S_ANG: begin
                r_angle <= w_angle;
                r_sqsel <= 1'b1;
            end
            S_DIVW: begin
                if (w_dv_done) begin
                    r_ax <= w_dv_quot;
                end
            end
            S_AMUL: begin
                r_aprod <= r_ga * r_ax;
            end
            S_AOUT: begin
                r_ang[r_k] <= sat32((64'(w_sprod) + 64'sd8388608) >>> 24);
                r_k        <= r_k + 2'd1;
            end
            S_FIN: begin
                if (w_out_free) begin
                    r_out_link <= r_link;
                    r_out_lin  <= r_lin;
                    r_out_ang  <= r_ang;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_link  = r_out_link;
    assign o_lin_vx    = r_out_lin[0];
    assign o_lin_vy    = r_out_lin[1];
    assign o_lin_vz    = r_out_lin[2];
    assign o_ang_vx    = r_out_ang[0];
    assign o_ang_vy    = r_out_ang[1];
    assign o_ang_vz    = r_out_ang[2];

    // A result waiting in the output register holds the next one back.
    `PTVC_ASSERT_NXT(a_fin_holds, i_clk, i_rst_n, (r_state == S_FIN) && r_out_valid && !i_out_ready, r_state == S_FIN, "result overwrote a pending result")
    // Stores, bad links and never-stored links start no computation.
    `PTVC_ASSERT_NXT(a_no_work, i_clk, i_rst_n, w_in_acc && !w_go, r_state == S_IDLE, "computation started without a valid target")
    // The square root unit reports completion only while it is awaited.
    `PTVC_ASSERT_IMP(a_sqrt_done, i_clk, i_rst_n, w_sq_done, r_state == S_SQRTW, "square root finished outside its wait state")
    // The divider reports completion only while it is awaited.
    `PTVC_ASSERT_IMP(a_div_done, i_clk, i_rst_n, w_dv_done, r_state == S_DIVW, "division finished outside its wait state")

endmodule

`default_nettype wire

@@ rtl/ptvc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; holds the per-link target poses.
`default_nettype none

module ptvc_ram #(
    parameter int unsigned WIDTH = 160,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                    i_wdata,
    input  wire logic                                i_re,
    input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/ptvc_sqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
// Depends on ptvc_pkg for widths.
`default_nettype none

module ptvc_sqrt
    import ptvc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [SQRT_IN_W-1:0]  i_radicand,
    output logic                       o_done,
    output logic [SQRT_OUT_W-1:0]      o_root
);

    localparam int unsigned REM_W = SQRT_OUT_W + 3;

    logic                  r_busy;
    logic                  r_done;
    logic [4:0]            r_cnt;
    logic [SQRT_IN_W-1:0]  r_num;
    logic [REM_W-1:0]      r_rem;
    logic [SQRT_OUT_W-1:0] r_root;
    logic [REM_W-1:0]      w_rem_sh;
    logic [REM_W-1:0]      w_trial;

    // Bring down the next two radicand bits and try the next root bit.
    assign w_rem_sh = {r_rem[REM_W-3:0], r_num[SQRT_IN_W-1 -: 2]};
    assign w_trial  = {1'b0, r_root, 2'b01};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[SQRT_IN_W-3:0], 2'b00};
            if (w_rem_sh >= w_trial) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[SQRT_OUT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[SQRT_OUT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

@@ rtl/ptvc_div.sv @@
// Restoring divider for the rotation axis, one quotient bit per cycle.
// Depends on ptvc_pkg; the numerator's upper part must lie below the divisor.
`default_nettype none

module ptvc_div
    import ptvc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DIV_NUM_W-1:0] i_num,
    input  wire logic [DIV_DEN_W-1:0] i_den,
    output logic                      o_done,
    output logic [DIV_Q_W-1:0]        o_quot
);

    localparam int unsigned REM_W = DIV_DEN_W + 1;

    logic                 r_busy;
    logic                 r_done;
    logic [4:0]           r_cnt;
    logic [REM_W-1:0]     r_rem;
    logic [DIV_Q_W-1:0]   r_nlo;
    logic [DIV_Q_W-1:0]   r_quot;
    logic [DIV_DEN_W-1:0] r_den;
    logic [REM_W-1:0]     w_rem_sh;
    logic                 w_fit;

    assign w_rem_sh = {r_rem[DIV_DEN_W-1:0], r_nlo[DIV_Q_W-1]};
    assign w_fit    = (w_rem_sh >= {1'b0, r_den});

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'(DIV_Q_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_Q_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Shift-subtract datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= REM_W'(i_num[DIV_NUM_W-1:DIV_Q_W]);
            r_nlo  <= i_num[DIV_Q_W-1:0];
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_nlo  <= {r_nlo[DIV_Q_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_Q_W-2:0], w_fit};
            r_rem  <= w_fit ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

@@ sim/pose_velocity_checker.sv @@
// Checker for the pose controller: watches the input, result and register channels,
// predicts each result and compares it field by field. Depends on ptvc_pkg.
`timescale 1ns / 100ps

module pose_velocity_checker
    import ptvc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic                    i_func,
    input  logic [LINK_W-1:0]       i_link_index,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic signed [Q_W-1:0]   i_quat_w,
    input  logic signed [Q_W-1:0]   i_quat_x,
    input  logic signed [Q_W-1:0]   i_quat_y,
    input  logic signed [Q_W-1:0]   i_quat_z,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [LINK_W-1:0]       i_out_link,
    input  logic signed [POS_W-1:0] i_lin_vx,
    input  logic signed [POS_W-1:0] i_lin_vy,
    input  logic signed [POS_W-1:0] i_lin_vz,
    input  logic signed [POS_W-1:0] i_ang_vx,
    input  logic signed [POS_W-1:0] i_ang_vy,
    input  logic signed [POS_W-1:0] i_ang_vz,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_AW-1:0]       i_cfg_index,
    input  logic [CFG_DW-1:0]       i_cfg_data,
    output int                      o_errors,
    output int                      o_pending
);

    typedef struct {
        logic [LINK_W-1:0]       link;
        logic signed [POS_W-1:0] lin[3];
        logic signed [POS_W-1:0] ang[3];
    } velocity_t;

    localparam longint HALF_PI_TURN = 64'sd52707179;

    longint arctan_q24 [0:23] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    // Mirror of the registers and the per-link target store.
    logic [GAIN_W-1:0]       lin_gain;
    logic [GAIN_W-1:0]       ang_gain;
    logic [PDB_W-1:0]        pos_band;
    logic [RDB_W-1:0]        rot_band;
    logic signed [POS_W-1:0] goal_pos [16][3];
    logic signed [Q_W-1:0]   goal_quat [16][4];
    logic                    goal_set [16];

    velocity_t expected_velocities[$];
    int        mismatches = 0;

    assign o_errors  = mismatches;
    assign o_pending = expected_velocities.size();

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint mag64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint unit_clip(logic signed [Q_W-1:0] q);
        longint v;
        v = q;
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return v;
    endfunction

    function automatic logic signed [POS_W-1:0] clip32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // Rotation angle 2*acos(w) for w in Q2.28, giving Q3.16 radians.
    function automatic longint rotation_angle(longint w);
        longint one;
        longint x;
        longint y;
        longint z;
        longint nx;
        longint ny;
        longint th;
        one = 64'sd1 <<< 28;
        if (w > one) w = one;
        if (w < -one) w = -one;
        x = mag64(w);
        y = longint'(floor_sqrt(longint'(one * one - w * w)));
        z = 0;
        for (int i = 0; i < 24; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + arctan_q24[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - arctan_q24[i];
            end
            x = nx;
            y = ny;
        end
        th = (w < 0) ? HALF_PI_TURN - z : z;
        if (th < 0) th = 0;
        if (th > HALF_PI_TURN) th = HALF_PI_TURN;
        return (th + 64) >>> 7;
    endfunction

    // Velocity command for an update of a stored link.
    function automatic velocity_t command_velocity(input logic [LINK_W-1:0] link,
                                                   input longint cur_pos[3],
                                                   input longint cur_quat[4]);
        velocity_t       r;
        longint          e[3];
        longint          t[4];
        longint          v[4];
        longint          band;
        longint          angle;
        longint          norm;
        longint          ga;
        longint          ax;
        longint unsigned ss;
        longint unsigned len;
        logic            move;
        r.link = link;
        band = longint'(pos_band);
        move = 1'b0;
        for (int k = 0; k < 3; k++) begin
            e[k] = longint'(goal_pos[link][k]) - cur_pos[k];
            if (mag64(e[k]) > band) move = 1'b1;
        end
        if (!move) begin
            ss = 0;
            for (int k = 0; k < 3; k++) ss = ss + longint'(e[k] * e[k]);
            move = ss > longint'(band * band);
        end
        for (int k = 0; k < 3; k++) begin
            r.lin[k] = move ? clip32((longint'(lin_gain) * e[k] + 128) >>> 8) : '0;
            r.ang[k] = '0;
        end
        // Error quaternion: target times the conjugate of the current pose.
        for (int k = 0; k < 4; k++) t[k] = unit_clip(goal_quat[link][k]);
        v[0] = t[0] * cur_quat[0] + t[1] * cur_quat[1] + t[2] * cur_quat[2]
             + t[3] * cur_quat[3];
        v[1] = cur_quat[0] * t[1] - t[0] * cur_quat[1] - t[2] * cur_quat[3]
             + t[3] * cur_quat[2];
        v[2] = cur_quat[0] * t[2] - t[0] * cur_quat[2] - t[3] * cur_quat[1]
             + t[1] * cur_quat[3];
        v[3] = cur_quat[0] * t[3] - t[0] * cur_quat[3] - t[1] * cur_quat[2]
             + t[2] * cur_quat[1];
        len = longint'(v[1] * v[1]) + longint'(v[2] * v[2]) + longint'(v[3] * v[3]);
        if (len != 0) begin
            angle = rotation_angle(v[0]);
            if (angle > longint'(rot_band)) begin
                norm = longint'(floor_sqrt(len));
                ga = longint'(ang_gain) * angle;
                for (int k = 0; k < 3; k++) begin
                    ax = ((mag64(v[k + 1]) <<< 16) + norm / 2) / norm;
                    if (v[k + 1] < 0) ax = -ax;
                    r.ang[k] = clip32((ga * ax + (64'sd1 <<< 23)) >>> 24);
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Register writes and input transactions update the mirror and the expectations.
    always @(posedge i_clk) begin
        longint    cur_pos[3];
        longint    cur_quat[4];
        velocity_t want;
        if (!i_rst_n) begin
            lin_gain = LIN_GAIN_RST;
            ang_gain = ANG_GAIN_RST;
            pos_band = POS_DB_RST;
            rot_band = ROT_DB_RST;
            for (int i = 0; i < 16; i++) goal_set[i] = 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LIN_GAIN: lin_gain = i_cfg_data[GAIN_W-1:0];
                    CFG_ANG_GAIN: ang_gain = i_cfg_data[GAIN_W-1:0];
                    CFG_POS_DB:   pos_band = i_cfg_data[PDB_W-1:0];
                    default:      rot_band = i_cfg_data[RDB_W-1:0];
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_func == FUNC_STORE) begin
                    goal_pos[i_link_index][0]  = i_pos_x;
                    goal_pos[i_link_index][1]  = i_pos_y;
                    goal_pos[i_link_index][2]  = i_pos_z;
                    goal_quat[i_link_index][0] = i_quat_w;
                    goal_quat[i_link_index][1] = i_quat_x;
                    goal_quat[i_link_index][2] = i_quat_y;
                    goal_quat[i_link_index][3] = i_quat_z;
                    goal_set[i_link_index]     = 1'b1;
                end else if (goal_set[i_link_index]) begin
                    cur_pos[0]  = i_pos_x;
                    cur_pos[1]  = i_pos_y;
                    cur_pos[2]  = i_pos_z;
                    cur_quat[0] = unit_clip(i_quat_w);
                    cur_quat[1] = unit_clip(i_quat_x);
                    cur_quat[2] = unit_clip(i_quat_y);
                    cur_quat[3] = unit_clip(i_quat_z);
                    want = command_velocity(i_link_index, cur_pos, cur_quat);
                    expected_velocities.push_back(want);
                end
            end
        end
    end

    // Each result transaction is compared with the oldest expectation.
    always @(posedge i_clk) begin
        velocity_t want;
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (expected_velocities.size() == 0) begin
                report_mismatch("unexpected result for link", i_out_link, -1);
            end else begin
                want = expected_velocities.pop_front();
                if (i_out_link !== want.link) report_mismatch("out_link", i_out_link, want.link);
                if (i_lin_vx !== want.lin[0]) report_mismatch("lin_vx", i_lin_vx, want.lin[0]);
                if (i_lin_vy !== want.lin[1]) report_mismatch("lin_vy", i_lin_vy, want.lin[1]);
                if (i_lin_vz !== want.lin[2]) report_mismatch("lin_vz", i_lin_vz, want.lin[2]);
                if (i_ang_vx !== want.ang[0]) report_mismatch("ang_vx", i_ang_vx, want.ang[0]);
                if (i_ang_vy !== want.ang[1]) report_mismatch("ang_vy", i_ang_vy, want.ang[1]);
                if (i_ang_vz !== want.ang[2]) report_mismatch("ang_vz", i_ang_vz, want.ang[2]);
            end
        end
    end

endmodule

@@ sim/tb_top.sv @@
// Top of the pose controller testbench: clock, reset, stimulus and verdict.
// Depends on ptvc_pkg, pose_target_velocity_controller and pose_velocity_checker.
`timescale 1ns / 100ps

module tb_top;
    import ptvc_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = 300;
    localparam int PHASE_ITEMS = 110;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic                    i_func = FUNC_STORE;
    logic [LINK_W-1:0]       i_link_index = '0;
    logic signed [POS_W-1:0] i_pos_x = '0;
    logic signed [POS_W-1:0] i_pos_y = '0;
    logic signed [POS_W-1:0] i_pos_z = '0;
    logic signed [Q_W-1:0]   i_quat_w = '0;
    logic signed [Q_W-1:0]   i_quat_x = '0;
    logic signed [Q_W-1:0]   i_quat_y = '0;
    logic signed [Q_W-1:0]   i_quat_z = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [LINK_W-1:0]       o_out_link;
    logic signed [POS_W-1:0] o_lin_vx;
    logic signed [POS_W-1:0] o_lin_vy;
    logic signed [POS_W-1:0] o_lin_vz;
    logic signed [POS_W-1:0] o_ang_vx;
    logic signed [POS_W-1:0] o_ang_vy;
    logic signed [POS_W-1:0] o_ang_vz;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_AW-1:0]       i_cfg_index = '0;
    logic [CFG_DW-1:0]       i_cfg_data = '0;

    int   errors;
    int   pending;
    logic calm = 1'b0;
    int   quiet_cycles = 0;
    int   items_sent = 0;
    int   settings_used = 1;

    // Stimulus-side copy of stored targets, used to aim updates near them.
    logic signed [POS_W-1:0] aim_pos [16][3];
    logic signed [Q_W-1:0]   aim_quat [16][4];
    logic                    aimed [16];

    pose_target_velocity_controller uut (.*);

    pose_velocity_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_func, .i_link_index,
        .i_pos_x, .i_pos_y, .i_pos_z, .i_quat_w, .i_quat_x, .i_quat_y, .i_quat_z,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out_link(o_out_link),
        .i_lin_vx(o_lin_vx), .i_lin_vy(o_lin_vy), .i_lin_vz(o_lin_vz),
        .i_ang_vx(o_ang_vx), .i_ang_vy(o_ang_vy), .i_ang_vz(o_ang_vz),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side stalls at random outside the calm stretch.
    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 31);
    end

    // Watchdog on cycles in which no transaction of any kind is accepted.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", pending);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pose(input logic func, input logic [LINK_W-1:0] link,
                             input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic [15:0] qw,
                             input logic [15:0] qx, input logic [15:0] qy,
                             input logic [15:0] qz);
        if (!calm && $urandom_range(0, 99) < 31) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 31);
        end
        i_in_valid   <= 1'b1;
        i_func       <= func;
        i_link_index <= link;
        i_pos_x      <= px;
        i_pos_y      <= py;
        i_pos_z      <= pz;
        i_quat_w     <= qw;
        i_quat_x     <= qx;
        i_quat_y     <= qy;
        i_quat_z     <= qz;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (func == FUNC_STORE) begin
            aim_pos[link]  = '{px, py, pz};
            aim_quat[link] = '{qw, qx, qy, qz};
            aimed[link]    = 1'b1;
        end
    endtask

    // Drain all results and let the block settle before a register write.
    task automatic write_register(input logic [CFG_AW-1:0] index, input logic [31:0] data);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [31:0] lg, input logic [31:0] ag,
                                 input logic [31:0] pdb, input logic [31:0] rdb);
        write_register(CFG_LIN_GAIN, lg);
        write_register(CFG_ANG_GAIN, ag);
        write_register(CFG_POS_DB, pdb);
        write_register(CFG_ROT_DB, rdb);
        settings_used++;
    endtask

    function automatic logic [31:0] offset_of(input logic [31:0] base);
        case ($urandom_range(0, 3))
            0:       return base + $urandom_range(0, 16000) - 8000;
            1:       return base + $urandom_range(0, 2097152) - 1048576;
            2:       return base;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] tilt_of(input logic [15:0] base);
        return base + 16'($urandom_range(0, 600)) - 16'd300;
    endfunction

    // Mostly updates near stored targets, some stores and some wild items.
    task automatic random_phase(input int count);
        logic [LINK_W-1:0] link;
        int                pick;
        int                qmode;
        logic [15:0]       q[4];
        repeat (count) begin
            pick = $urandom_range(0, 99);
            link = $urandom_range(0, 15);
            if (pick < 20) begin
                send_pose(FUNC_STORE, link, offset_of(0), offset_of(0), offset_of(0),
                          $urandom, $urandom, $urandom, $urandom);
            end else if (pick < 28 || !aimed[link]) begin
                send_pose(FUNC_UPDATE, link, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
            end else begin
                qmode = $urandom_range(0, 9);
                for (int k = 0; k < 4; k++) begin
                    if (qmode < 3) q[k] = aim_quat[link][k];
                    else if (qmode < 7) q[k] = tilt_of(aim_quat[link][k]);
                    else q[k] = 16'($urandom_range(0, 32768)) - 16'd16384;
                end
                send_pose(FUNC_UPDATE, link, offset_of(aim_pos[link][0]),
                          offset_of(aim_pos[link][1]), offset_of(aim_pos[link][2]),
                          q[0], q[1], q[2], q[3]);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++) aimed[i] = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under the reset settings.
        send_pose(FUNC_UPDATE, 4'd5, 0, 0, 0, 16384, 0, 0, 0);
        send_pose(FUNC_STORE, 4'd0, 0, 0, 0, 16384, 0, 0, 0);
        send_pose(FUNC_UPDATE, 4'd0, 0, 0, 0, 16384, 0, 0, 0);
        send_pose(FUNC_UPDATE, 4'd0, 100, -100, 50, 16383, 100, 0, 0);
        send_pose(FUNC_UPDATE, 4'd0, 32'h7fff_ffff, 32'h8000_0000, 256, 0, 16384, 0, 0);
        send_pose(FUNC_UPDATE, 4'd0, 0, 0, 0, -16384, 0, 0, 0);
        send_pose(FUNC_UPDATE, 4'd0, 4000, 4000, 4000, 11585, 0, 11585, 0);
        send_pose(FUNC_UPDATE, 4'd0, 0, 0, 0, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_pose(FUNC_STORE, 4'd15, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  -16384, 0, 0, 16384);
        send_pose(FUNC_UPDATE, 4'd15, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  16384, 0, 0, 0);
        send_pose(FUNC_STORE, 4'd3, 32'hffff_ffff, 1, 0, 16384, 0, 0, 0);
        send_pose(FUNC_UPDATE, 4'd3, 0, 0, 0, -11585, 0, 0, 11585);
        send_pose(FUNC_UPDATE, 4'd3, 0, 0, 0, 0, 0, 0, 16384);
        send_pose(FUNC_UPDATE, 4'd3, 6554, 0, 0, 16384, 0, -16384, 0);

        apply_setting(32'hffff_ffff, 32'h0000_ffff, 0, 0);
        send_pose(FUNC_UPDATE, 4'd15, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  0, 16384, 0, 0);
        send_pose(FUNC_UPDATE, 4'd0, 1, 0, 0, 16384, 0, 0, 1);
        random_phase(PHASE_ITEMS);

        // Gains off, deadbands at their largest, with junk in the high bits.
        apply_setting(32'hffff_0000, 32'h1234_0000, 32'hffff_ffff, 32'hfff6_487f);
        calm = 1'b1;
        random_phase(PHASE_ITEMS);
        calm = 1'b0;

        apply_setting($urandom, $urandom, $urandom_range(0, 200000), $urandom_range(0, 300000));
        random_phase(PHASE_ITEMS);

        apply_setting($urandom, $urandom, $urandom, $urandom);
        random_phase(PHASE_ITEMS);

        apply_setting(LIN_GAIN_RST, ANG_GAIN_RST, POS_DB_RST, ROT_DB_RST);
        random_phase(PHASE_ITEMS);

        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Run covered %0d input transactions under %0d register settings,",
                 items_sent, settings_used);
        $display("with stores, updates of unset links and random stalls on both sides.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
